// ----- src/pesb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesb_pkg
// Shared types, constants and the rounding and saturation helpers of the particle step pipeline.
// ----------------------------------------------------------------------------
package pesb_pkg;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_REFLECT_ENABLE = 3'd0;
    localparam reg_index_t REG_BOX_LEFT       = 3'd1;
    localparam reg_index_t REG_BOX_TOP        = 3'd2;
    localparam reg_index_t REG_BOX_WIDTH      = 3'd3;
    localparam reg_index_t REG_BOX_HEIGHT     = 3'd4;
    localparam reg_index_t REG_BOUNCE_DAMPING = 3'd5;

    localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S24_MIN = -24'sh800000;
    localparam logic [23:0] AGE_MAX = 24'hFFFFFF;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] DRAG_MIN = 17'd55706;
    // ceil(2^22 / 5); exact quotient by five for any 20-bit numerator
    localparam logic [19:0] DIV5_MAGIC = 20'd838861;
    localparam logic [40:0] HALF_Q16 = 41'd32768;

    typedef struct packed {
        logic              reflect;
        logic signed [23:0] left;
        logic signed [23:0] top;
        logic signed [24:0] right;
        logic signed [24:0] bottom;
        logic [16:0]       damp;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [23:0]       age;
        logic [23:0]       lifetime;
        logic [15:0]       step_time;
        logic              active;
    } particle_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [15:0]       step_time;
        logic [23:0]       age;
        logic              alive;
        logic              active;
    } kin_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [23:0]       age;
        logic              alive;
        logic              active;
    } body_t;

    typedef struct packed {
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] new_vel_x;
        logic signed [23:0] new_vel_y;
        logic [23:0]       new_age;
        logic              alive;
    } result_t;

    function automatic logic signed [23:0] sat25(input logic signed [24:0] v);
        logic signed [23:0] r;
        if (v > 25'(S24_MAX)) begin
            r = S24_MAX;
        end else if (v < 25'(S24_MIN)) begin
            r = S24_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Divide by 2^16, rounding to nearest with ties away from zero.
    // A negative value gets one less than half, then the arithmetic shift.
    function automatic logic signed [24:0] round_q16(input logic signed [40:0] p);
        logic signed [40:0] s;
        s = p + (p[40] ? $signed(HALF_Q16 - 41'd1) : $signed(HALF_Q16));
        return s[40:16];
    endfunction

endpackage

// ----- src/pesb_velocity.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesb_velocity
// Three stages: age, gravity and drag quotient; drag factor and multiply; drag rounding.
// ----------------------------------------------------------------------------
module pesb_velocity
    import pesb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  particle_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output kin_t      out_data
);

    typedef struct packed {
        kin_t        kin;
        logic [16:0] quot;
    } s1_t;

    typedef struct packed {
        kin_t              kin;
        logic signed [40:0] prod;
    } s2_t;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    kin_t s3_reg, s3_next;

    logic [15:0]        dt_e;
    logic [24:0]        age_sum;
    logic [23:0]        age_new;
    logic [19:0]        grav_sum;
    logic signed [24:0] vy_sum;
    logic [19:0]        num;
    logic [39:0]        quot_prod;
    logic [16:0]        f_raw;
    logic [16:0]        f_drag;
    logic signed [41:0] vx_w;
    logic signed [41:0] f_w;
    logic signed [41:0] prod_w;
    logic signed [24:0] vx_round;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // An inactive particle runs with a zero step, which leaves every field as it was.
    always_comb
    begin
        dt_e      = in_data.active ? in_data.step_time : 16'd0;
        age_sum   = {1'b0, in_data.age} + {9'd0, dt_e};
        age_new   = age_sum[24] ? AGE_MAX : age_sum[23:0];
        grav_sum  = ({4'd0, dt_e} * 20'd15 + 20'd8) >> 4;
        vy_sum    = {in_data.vel_y[23], in_data.vel_y} + $signed({9'd0, grav_sum[15:0]});
        num       = {1'b0, dt_e, 3'b000} + 20'd2;
        quot_prod = num * DIV5_MAGIC;

        s1_next.kin.pos_x     = in_data.pos_x;
        s1_next.kin.pos_y     = in_data.pos_y;
        s1_next.kin.vel_x     = in_data.vel_x;
        s1_next.kin.vel_y     = sat25(vy_sum);
        s1_next.kin.step_time = dt_e;
        s1_next.kin.age       = age_new;
        s1_next.kin.alive     = in_data.active && (age_new < in_data.lifetime);
        s1_next.kin.active    = in_data.active;
        s1_next.quot          = quot_prod[38:22];
    end

    // The floor is decided on the quotient, since a large step wraps the difference.
    always_comb
    begin
        f_raw  = ONE_Q16 - s1_reg.quot;
        f_drag = (s1_reg.quot > (ONE_Q16 - DRAG_MIN)) ? DRAG_MIN : f_raw;
        vx_w   = 42'(s1_reg.kin.vel_x);
        f_w    = $signed({25'd0, f_drag});
        prod_w = vx_w * f_w;
        s2_next.kin  = s1_reg.kin;
        s2_next.prod = prod_w[40:0];
    end

    always_comb
    begin
        vx_round      = round_q16(s2_reg.prod);
        s3_next       = s2_reg.kin;
        s3_next.vel_x = vx_round[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

// ----- src/pesb_integrate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesb_integrate
// Two stages: velocity times step, then rounding and saturating position add.
// ----------------------------------------------------------------------------
module pesb_integrate
    import pesb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  kin_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output body_t out_data
);

    typedef struct packed {
        body_t             body;
        logic signed [40:0] dx;
        logic signed [40:0] dy;
    } s4_t;

    logic  v4_reg, v5_reg;
    logic  rdy4, rdy5;
    s4_t   s4_reg, s4_next;
    body_t s5_reg, s5_next;

    logic signed [40:0] dt_w;
    logic signed [24:0] dx_r;
    logic signed [24:0] dy_r;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_comb
    begin
        dt_w = $signed({25'd0, in_data.step_time});
        s4_next.body.pos_x  = in_data.pos_x;
        s4_next.body.pos_y  = in_data.pos_y;
        s4_next.body.vel_x  = in_data.vel_x;
        s4_next.body.vel_y  = in_data.vel_y;
        s4_next.body.age    = in_data.age;
        s4_next.body.alive  = in_data.alive;
        s4_next.body.active = in_data.active;
        s4_next.dx = 41'(in_data.vel_x) * dt_w;
        s4_next.dy = 41'(in_data.vel_y) * dt_w;
    end

    always_comb
    begin
        dx_r = round_q16(s4_reg.dx);
        dy_r = round_q16(s4_reg.dy);
        s5_next       = s4_reg.body;
        s5_next.pos_x = sat25(25'(s4_reg.body.pos_x) + dx_r);
        s5_next.pos_y = sat25(25'(s4_reg.body.pos_y) + dy_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            s4_reg <= s4_next;
        end
        if (rdy5 && v4_reg)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

endmodule

// ----- src/pesb_bounce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesb_bounce
// Two stages: edge tests and damping multiply, then rounding into the result.
// ----------------------------------------------------------------------------
module pesb_bounce
    import pesb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  body_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [23:0]       age;
        logic              alive;
        logic              hit_x;
        logic              neg_x;
        logic              hit_y;
        logic              neg_y;
        logic [40:0]       prod_x;
        logic [40:0]       prod_y;
    } s6_t;

    logic    v6_reg, v7_reg;
    logic    rdy6, rdy7;
    s6_t     s6_reg, s6_next;
    result_t s7_reg, s7_next;

    logic        armed;
    logic        lo_x, hi_x, lo_y, hi_y;
    logic [23:0] mag_x, mag_y;
    logic [40:0] sum_x, sum_y;
    logic [24:0] m_x, m_y;
    logic [23:0] lim_x, lim_y;

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign in_ready = rdy6;

    // The low edge is tested first on each axis.
    always_comb
    begin
        armed = cfg.reflect && in_data.active;
        lo_x  = armed && (in_data.pos_x < cfg.left);
        hi_x  = armed && !lo_x && (25'(in_data.pos_x) > cfg.right);
        lo_y  = armed && (in_data.pos_y < cfg.top);
        hi_y  = armed && !lo_y && (25'(in_data.pos_y) > cfg.bottom);
        mag_x = in_data.vel_x[23] ? (~in_data.vel_x + 24'd1) : in_data.vel_x;
        mag_y = in_data.vel_y[23] ? (~in_data.vel_y + 24'd1) : in_data.vel_y;

        s6_next.pos_x  = lo_x ? cfg.left : (hi_x ? cfg.right[23:0] : in_data.pos_x);
        s6_next.pos_y  = lo_y ? cfg.top : (hi_y ? cfg.bottom[23:0] : in_data.pos_y);
        s6_next.vel_x  = in_data.vel_x;
        s6_next.vel_y  = in_data.vel_y;
        s6_next.age    = in_data.age;
        s6_next.alive  = in_data.alive;
        s6_next.hit_x  = lo_x || hi_x;
        s6_next.neg_x  = hi_x;
        s6_next.hit_y  = lo_y || hi_y;
        s6_next.neg_y  = hi_y;
        s6_next.prod_x = {17'd0, mag_x} * {24'd0, cfg.damp};
        s6_next.prod_y = {17'd0, mag_y} * {24'd0, cfg.damp};
    end

    // A full negative speed at unit damping rounds to one past the maximum.
    always_comb
    begin
        sum_x = s6_reg.prod_x + HALF_Q16;
        sum_y = s6_reg.prod_y + HALF_Q16;
        m_x   = sum_x[40:16];
        m_y   = sum_y[40:16];
        lim_x = (m_x > 25'(S24_MAX)) ? S24_MAX : m_x[23:0];
        lim_y = (m_y > 25'(S24_MAX)) ? S24_MAX : m_y[23:0];

        s7_next.new_pos_x = s6_reg.pos_x;
        s7_next.new_pos_y = s6_reg.pos_y;
        s7_next.new_vel_x = !s6_reg.hit_x ? s6_reg.vel_x :
                            (s6_reg.neg_x ? (~lim_x + 24'd1) : lim_x);
        s7_next.new_vel_y = !s6_reg.hit_y ? s6_reg.vel_y :
                            (s6_reg.neg_y ? (~lim_y + 24'd1) : lim_y);
        s7_next.new_age   = s6_reg.age;
        s7_next.alive     = s6_reg.alive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
            begin
                v6_reg <= in_valid;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && in_valid)
        begin
            s6_reg <= s6_next;
        end
        if (rdy7 && v6_reg)
        begin
            s7_reg <= s7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_data  = s7_reg;

endmodule

// ----- src/particle_euler_step_with_bounce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_step_with_bounce
// One Euler time step of a particle with gravity, drag and box reflection.
// ----------------------------------------------------------------------------
// The block takes one particle request per clock when not stalled and returns
// its updated state through a seven-stage pipeline in which no stage
// holds more than one level of multiplication: the divide-by-five of the drag
// term, the drag multiply, the pair of position multiplies and the pair of
// damping multiplies each own a stage. Each stage moves on as soon as the stage
// after it is empty or moving, so a stall at the output fills the bubbles
// first and only then holds the input. Configuration is written through a
// plain write port and must stay unchanged while requests are in flight.
// ----------------------------------------------------------------------------
module particle_euler_step_with_bounce
    import pesb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  reg_index_t         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] vel_x,
    input  logic signed [23:0] vel_y,
    input  logic [23:0]        age,
    input  logic [23:0]        lifetime,
    input  logic [15:0]        step_time,
    input  logic               active_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] new_pos_x,
    output logic signed [23:0] new_pos_y,
    output logic signed [23:0] new_vel_x,
    output logic signed [23:0] new_vel_y,
    output logic [23:0]        new_age,
    output logic               alive
);

    logic               enable_reg;
    logic signed [23:0] left_reg;
    logic signed [23:0] top_reg;
    logic [22:0]        width_reg;
    logic [22:0]        height_reg;
    logic [16:0]        damp_reg;

    cfg_t      cfg;
    particle_t in_data;
    kin_t      kin;
    body_t     body;
    result_t   res;
    logic      in_ready;
    logic      kin_valid, kin_ready;
    logic      body_valid, body_ready;

    // Damping values above one are stored as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            damp_reg   <= ONE_Q16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REFLECT_ENABLE: enable_reg <= cfg_data[0];
                REG_BOX_LEFT:       left_reg   <= cfg_data;
                REG_BOX_TOP:        top_reg    <= cfg_data;
                REG_BOX_WIDTH:      width_reg  <= cfg_data[22:0];
                REG_BOX_HEIGHT:     height_reg <= cfg_data[22:0];
                REG_BOUNCE_DAMPING:
                begin
                    damp_reg <= (cfg_data[16:0] > ONE_Q16) ? ONE_Q16 : cfg_data[16:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.reflect = enable_reg && (width_reg != '0) && (height_reg != '0);
        cfg.left    = left_reg;
        cfg.top     = top_reg;
        cfg.right   = 25'(left_reg) + $signed({2'b00, width_reg});
        cfg.bottom  = 25'(top_reg) + $signed({2'b00, height_reg});
        cfg.damp    = damp_reg;

        in_data.pos_x     = pos_x;
        in_data.pos_y     = pos_y;
        in_data.vel_x     = vel_x;
        in_data.vel_y     = vel_y;
        in_data.age       = age;
        in_data.lifetime  = lifetime;
        in_data.step_time = step_time;
        in_data.active    = active_in;
    end

    pesb_velocity u_velocity (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (kin_valid),
        .out_ready (kin_ready),
        .out_data  (kin)
    );

    pesb_integrate u_integrate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (kin_valid),
        .in_ready  (kin_ready),
        .in_data   (kin),
        .out_valid (body_valid),
        .out_ready (body_ready),
        .out_data  (body)
    );

    pesb_bounce u_bounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (body_valid),
        .in_ready  (body_ready),
        .in_data   (body),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_data  (res)
    );

    assign in_stall  = !in_ready;
    assign new_pos_x = res.new_pos_x;
    assign new_pos_y = res.new_pos_y;
    assign new_vel_x = res.new_vel_x;
    assign new_vel_y = res.new_vel_y;
    assign new_age   = res.new_age;
    assign alive     = res.alive;

endmodule
